// ===== sv/cll_pkg.sv =====
`timescale 1ns / 1ps

package cll_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_NAME    = 2'd1,
    PH_PARAMS  = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [2:0] CALL_PLAIN = 3'd0;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_NAME    = 3'd1;
  localparam logic [2:0] ERR_EMPTY_NAME  = 3'd2;
  localparam logic [2:0] ERR_BAD_PARAM   = 3'd3;
  localparam logic [2:0] ERR_EMPTY_PARAM = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG    = 3'd5;

  localparam logic [7:0] CH_PRINT_LO = 8'd33;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;
  localparam logic [7:0] CH_OPEN     = "(";
  localparam logic [7:0] CH_CLOSE    = ")";
  localparam logic [7:0] CH_COMMA    = ",";
  localparam logic [7:0] CH_QUOTE    = "\"";

  // keywords in the order lf, lv, get, set, read, write; call type is index + 1
  localparam int KW_COUNT = 6;
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5};
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"l", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "v", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "e", "t",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "e", "t",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "a",   "d",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "r", "i",   "t",   "e",   8'h00, 8'h00, 8'h00}
  };

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_start;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] call_type;
    logic [2:0] error_code;
    logic [7:0] name_end;
    logic [7:0] param_count;
    logic [7:0] param_index;
    logic [8:0] param_start;
    logic [7:0] param_end;
    logic       param_is_string;
    logic       last;
  } res_t;

  // results produced by one item, r0 first
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== sv/cll_stream_if.sv =====
`timescale 1ns / 1ps

interface cll_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/cll_lexer.sv =====
`timescale 1ns / 1ps

module cll_lexer #(
  parameter int LINE_LENGTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  cll_stream_if.sink   in_chan,
  input  logic         room,
  output cll_pkg::push_t push
);

  localparam logic [8:0] LINE_MAX = 9'(LINE_LENGTH);

  logic             ir_valid;
  logic [7:0]       ir_ch;
  logic             ir_ls;
  logic             fire;

  cll_pkg::phase_t  phase, phase_next, phase_e;
  logic [8:0]       position, pos_e;
  logic [7:0]       name_last, nl_e;
  logic [8:0]       token_begin, tb_e;
  logic [7:0]       token_count, tc_e, tc_after;
  logic [7:0]       prev_char, pc_e;
  logic [5:0]       kw_match, kw_e, kw_hit;

  logic             active, name_char, printable;
  logic             err, open_paren, tok, done, advance;
  logic [2:0]       err_code;
  logic [2:0]       call_type;
  logic             is_str;
  logic [8:0]       name_len;
  cll_pkg::res_t    tok_res, done_res, err_res;

  assign fire = ir_valid && room;
  assign in_chan.ready = !ir_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_chan.ready) begin
      ir_valid <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      ir_ch <= in_chan.data.ch;
      ir_ls <= in_chan.data.line_start;
    end
  end

  // line start drops the line in progress and lexes from a clean state
  assign phase_e = ir_ls ? cll_pkg::PH_NAME : phase;
  assign pos_e   = ir_ls ? 9'd0 : position;
  assign nl_e    = ir_ls ? 8'd0 : name_last;
  assign tb_e    = ir_ls ? 9'd0 : token_begin;
  assign tc_e    = ir_ls ? 8'd0 : token_count;
  assign pc_e    = ir_ls ? 8'd0 : prev_char;
  assign kw_e    = ir_ls ? 6'h3f : kw_match;

  assign active = (phase_e == cll_pkg::PH_NAME) || (phase_e == cll_pkg::PH_PARAMS);
  assign name_char = (ir_ch >= "a" && ir_ch <= "z") || (ir_ch >= "A" && ir_ch <= "Z") ||
                     (ir_ch >= "0" && ir_ch <= "9") || (ir_ch == "_");
  assign printable = (ir_ch >= cll_pkg::CH_PRINT_LO) && (ir_ch <= cll_pkg::CH_PRINT_HI);

  always_comb begin
    err        = 1'b0;
    err_code   = cll_pkg::ERR_NONE;
    open_paren = 1'b0;
    tok        = 1'b0;
    done       = 1'b0;
    if (active) begin
      if (pos_e >= LINE_MAX) begin
        err      = 1'b1;
        err_code = cll_pkg::ERR_TOO_LONG;
      end else if (phase_e == cll_pkg::PH_NAME) begin
        if (ir_ch == cll_pkg::CH_OPEN) begin
          if (pos_e == 9'd0) begin
            err      = 1'b1;
            err_code = cll_pkg::ERR_EMPTY_NAME;
          end else begin
            open_paren = 1'b1;
          end
        end else if (!name_char) begin
          err      = 1'b1;
          err_code = cll_pkg::ERR_BAD_NAME;
        end
      end else begin
        if (!printable) begin
          err      = 1'b1;
          err_code = cll_pkg::ERR_BAD_PARAM;
        end else if (ir_ch == cll_pkg::CH_COMMA) begin
          if (pos_e == tb_e) begin
            err      = 1'b1;
            err_code = cll_pkg::ERR_EMPTY_PARAM;
          end else begin
            tok = 1'b1;
          end
        end else if (ir_ch == cll_pkg::CH_CLOSE) begin
          // "name()" closes with no token
          if (pos_e != ({1'b0, nl_e} + 9'd2)) begin
            if (pos_e == tb_e) begin
              err      = 1'b1;
              err_code = cll_pkg::ERR_EMPTY_PARAM;
            end else begin
              tok = 1'b1;
            end
          end
          done = !err;
        end
      end
    end
  end

  assign advance = fire && active && !err;

  always_comb begin
    for (int i = 0; i < cll_pkg::KW_COUNT; i++) begin
      kw_hit[i] = (pos_e < 9'(cll_pkg::KW_LEN[i])) &&
                  (ir_ch == cll_pkg::KW_TEXT[i][pos_e[2:0]]);
    end
  end

  assign name_len = {1'b0, nl_e} + 9'd1;

  always_comb begin
    call_type = cll_pkg::CALL_PLAIN;
    for (int i = cll_pkg::KW_COUNT - 1; i >= 0; i--) begin
      if (kw_e[i] && (9'(cll_pkg::KW_LEN[i]) == name_len)) begin
        call_type = 3'(i + 1);
      end
    end
  end

  assign tc_after = (tok && tc_e != 8'hff) ? tc_e + 8'd1 : tc_e;
  assign is_str   = (pc_e == cll_pkg::CH_QUOTE);

  // next phase
  always_comb begin
    phase_next = phase;
    if (fire) begin
      if (err || done) begin
        phase_next = cll_pkg::PH_STOPPED;
      end else if (open_paren) begin
        phase_next = cll_pkg::PH_PARAMS;
      end else begin
        phase_next = phase_e;
      end
    end
  end

  // results
  always_comb begin
    tok_res                 = '0;
    tok_res.kind            = cll_pkg::KIND_TOKEN;
    tok_res.name_end        = nl_e;
    tok_res.param_index     = tc_e;
    tok_res.param_start     = is_str ? tb_e + 9'd1 : tb_e;
    tok_res.param_end       = is_str ? 8'(pos_e - 9'd2) : 8'(pos_e - 9'd1);
    tok_res.param_is_string = is_str;

    done_res             = '0;
    done_res.kind        = cll_pkg::KIND_DONE;
    done_res.call_type   = call_type;
    done_res.name_end    = nl_e;
    done_res.param_count = tc_after;
    done_res.last        = 1'b1;

    err_res            = '0;
    err_res.kind       = cll_pkg::KIND_ERROR;
    err_res.error_code = err_code;
    err_res.last       = 1'b1;

    push.n  = 2'd0;
    push.r0 = tok_res;
    push.r1 = done_res;
    if (fire) begin
      if (err) begin
        push.n  = 2'd1;
        push.r0 = err_res;
      end else if (tok && done) begin
        push.n = 2'd2;
      end else if (tok) begin
        push.n = 2'd1;
      end else if (done) begin
        push.n  = 2'd1;
        push.r0 = done_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cll_pkg::PH_IDLE;
      position    <= 9'd0;
      name_last   <= 8'd0;
      token_begin <= 9'd0;
      token_count <= 8'd0;
      prev_char   <= 8'd0;
      kw_match    <= 6'h3f;
    end else if (fire) begin
      phase       <= phase_next;
      position    <= (advance && pos_e != 9'h1ff) ? pos_e + 9'd1 : pos_e;
      name_last   <= (advance && open_paren) ? 8'(pos_e - 9'd1) : nl_e;
      token_begin <= (advance && (open_paren || tok && !done)) ? pos_e + 9'd1 : tb_e;
      token_count <= advance ? tc_after : tc_e;
      prev_char   <= advance ? ir_ch : pc_e;
      kw_match    <= (advance && phase_e == cll_pkg::PH_NAME && !open_paren) ?
                     (kw_e & kw_hit) : kw_e;
    end
  end

  a_err_stops: assert property (@(posedge clk) disable iff (rst)
    (fire && err) |=> (phase == cll_pkg::PH_STOPPED))
    else $error("error result did not stop the line");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (push.r0.kind == cll_pkg::KIND_TOKEN &&
                          push.r1.kind == cll_pkg::KIND_DONE))
    else $error("two results must be token then done");

  a_line_start: assert property (@(posedge clk) disable iff (rst)
    (fire && ir_ls) |=> (phase != cll_pkg::PH_IDLE))
    else $error("line start left the lexer idle");

endmodule

// ===== sv/cll_out_queue.sv =====
`timescale 1ns / 1ps

module cll_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  cll_pkg::push_t  push,
  output logic            room,
  cll_stream_if.source    out_chan
);

  cll_pkg::res_t q [cll_pkg::QUEUE_DEPTH];
  logic [1:0]    wptr, rptr;
  logic [2:0]    count, count_next;
  logic          pop;

  assign pop            = out_chan.valid && out_chan.ready;
  assign out_chan.valid = (count != 3'd0);
  assign out_chan.data  = q[rptr];
  // an item may bring two results
  assign room           = (count <= 3'(cll_pkg::QUEUE_DEPTH - 2));
  assign count_next     = count + 3'(push.n) - 3'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      wptr  <= wptr + push.n;
      rptr  <= rptr + 2'(pop);
      count <= count_next;
    end
    if (push.n != 2'd0) begin
      q[wptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q[wptr + 2'd1] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(cll_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (count <= 3'(cll_pkg::QUEUE_DEPTH - 2)))
    else $error("push without room for two results");

  a_pop_next: assert property (@(posedge clk) disable iff (rst)
    (pop && push.n == 2'd0) |=> (count == $past(count) - 3'd1))
    else $error("pop did not drain one entry");

endmodule

// ===== sv/command_line_call_lexer.sv =====
`timescale 1ns / 1ps

// channel    dir  payload                                    handshake
// in_chan    in   ch, line_start                             valid / ready
// out_chan   out  kind, call_type, error_code, name_end,     valid / ready
//                 param_count, param_index, param_start,
//                 param_end, param_is_string, last
//
// one character per cycle: an input register, combinational lexing logic,
// then a four-entry result queue that holds the results until they are read.
// a closing parenthesis after a token gives two results, drained one per ready cycle.
// the lexer stalls only while the queue holds more than two results.
// rst is synchronous and clears the line state; the line waits for line_start.

module command_line_call_lexer #(
  parameter int LINE_LENGTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  cll_stream_if.sink   in_chan,
  cll_stream_if.source out_chan
);

  cll_pkg::push_t push;
  logic           room;

  cll_lexer #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_lexer (
    .clk     (clk),
    .rst     (rst),
    .in_chan (in_chan),
    .room    (room),
    .push    (push)
  );

  cll_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

// ===== test/command_line_call_lexer_test.sv =====
`timescale 1ns / 1ps

module command_line_call_lexer_test;

  localparam int LINE_LENGTH = 256;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_CHARS = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cll_stream_if #(.T(cll_pkg::in_item_t)) in_chan ();
  cll_stream_if #(.T(cll_pkg::res_t)) out_chan ();

  command_line_call_lexer #(.LINE_LENGTH(LINE_LENGTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  // lexer state as the block should hold it
  cll_pkg::phase_t lx_phase = cll_pkg::PH_IDLE;
  logic [8:0] lx_pos = '0;
  logic [7:0] lx_name_last = '0;
  logic [8:0] lx_tok_begin = '0;
  logic [7:0] lx_tok_count = '0;
  logic [7:0] lx_prev = '0;
  logic [cll_pkg::KW_COUNT-1:0] lx_kw = '1;

  cll_pkg::res_t lexer_results[$];
  cll_pkg::in_item_t cmd_chars[$];
  logic [7:0] line_buf[$];
  string kw_names[cll_pkg::KW_COUNT] = '{"lf", "lv", "get", "set", "read", "write"};

  int unsigned failures = 0;
  int unsigned chars_total = 0;
  int unsigned chars_accepted = 0;
  int unsigned body_chars = 0;
  int unsigned lines_sent = 0;
  int unsigned results_seen = 0;
  int unsigned tokens_seen = 0;
  int unsigned done_seen = 0;
  int unsigned errors_seen = 0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned quiet_cycles = 0;

  function void stop_line(logic [2:0] code);
    cll_pkg::res_t r;
    r = '0;
    r.kind = cll_pkg::KIND_ERROR;
    r.error_code = code;
    r.last = 1'b1;
    lexer_results.push_back(r);
    lx_phase = cll_pkg::PH_STOPPED;
  endfunction

  function void push_token();
    cll_pkg::res_t r;
    r = '0;
    r.kind = cll_pkg::KIND_TOKEN;
    r.name_end = lx_name_last;
    r.param_index = lx_tok_count;
    // a token ending in a quote is taken as quoted at both ends
    r.param_is_string = (lx_prev == cll_pkg::CH_QUOTE);
    r.param_start = r.param_is_string ? lx_tok_begin + 9'd1 : lx_tok_begin;
    r.param_end = r.param_is_string ? 8'(lx_pos - 9'd2) : 8'(lx_pos - 9'd1);
    lexer_results.push_back(r);
    if (lx_tok_count != 8'd255) lx_tok_count++;
  endfunction

  function void lex_char(cll_pkg::in_item_t it);
    cll_pkg::res_t r;
    logic [2:0] ctype;
    int i;
    if (it.line_start) begin
      lx_pos = '0;
      lx_name_last = '0;
      lx_tok_begin = '0;
      lx_tok_count = '0;
      lx_prev = '0;
      lx_kw = '1;
      lx_phase = cll_pkg::PH_NAME;
    end else if (lx_phase != cll_pkg::PH_NAME && lx_phase != cll_pkg::PH_PARAMS) begin
      return;
    end
    if (lx_pos >= LINE_LENGTH) begin
      stop_line(cll_pkg::ERR_TOO_LONG);
      return;
    end
    if (lx_phase == cll_pkg::PH_NAME) begin
      if (it.ch == cll_pkg::CH_OPEN) begin
        if (lx_pos == 0) begin
          stop_line(cll_pkg::ERR_EMPTY_NAME);
          return;
        end
        lx_name_last = 8'(lx_pos - 9'd1);
        lx_tok_begin = lx_pos + 9'd1;
        lx_phase = cll_pkg::PH_PARAMS;
      end else if ((it.ch >= "a" && it.ch <= "z") || (it.ch >= "A" && it.ch <= "Z") ||
                   (it.ch >= "0" && it.ch <= "9") || it.ch == "_") begin
        for (i = 0; i < cll_pkg::KW_COUNT; i++) begin
          if (lx_pos >= cll_pkg::KW_LEN[i]) lx_kw[i] = 1'b0;
          else if (cll_pkg::KW_TEXT[i][lx_pos[2:0]] != it.ch) lx_kw[i] = 1'b0;
        end
      end else begin
        stop_line(cll_pkg::ERR_BAD_NAME);
        return;
      end
    end else begin
      if (it.ch < cll_pkg::CH_PRINT_LO || it.ch > cll_pkg::CH_PRINT_HI) begin
        stop_line(cll_pkg::ERR_BAD_PARAM);
        return;
      end
      if (it.ch == cll_pkg::CH_COMMA) begin
        if (lx_pos == lx_tok_begin) begin
          stop_line(cll_pkg::ERR_EMPTY_PARAM);
          return;
        end
        push_token();
        lx_tok_begin = lx_pos + 9'd1;
      end else if (it.ch == cll_pkg::CH_CLOSE) begin
        // name() has no token at all
        if (lx_pos != 9'(lx_name_last) + 9'd2) begin
          if (lx_pos == lx_tok_begin) begin
            stop_line(cll_pkg::ERR_EMPTY_PARAM);
            return;
          end
          push_token();
        end
        ctype = cll_pkg::CALL_PLAIN;
        for (i = cll_pkg::KW_COUNT - 1; i >= 0; i--) begin
          if (lx_kw[i] && 9'(cll_pkg::KW_LEN[i]) == 9'(lx_name_last) + 9'd1) begin
            ctype = 3'(i + 1);
          end
        end
        r = '0;
        r.kind = cll_pkg::KIND_DONE;
        r.call_type = ctype;
        r.name_end = lx_name_last;
        r.param_count = lx_tok_count;
        r.last = 1'b1;
        lexer_results.push_back(r);
        lx_phase = cll_pkg::PH_STOPPED;
      end
    end
    lx_prev = it.ch;
    if (lx_pos != 9'h1FF) lx_pos++;
  endfunction

  // idle share changes every 150 items, from none to heavy
  function automatic int unsigned idle_cycles(int unsigned count);
    int unsigned pct;
    case ((count / 150) % 4)
      0: pct = 0;
      1: pct = 25;
      2: pct = 60;
      default: pct = 90;
    endcase
    return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 16) : 0;
  endfunction

  function void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endfunction

  function void push_char(logic [7:0] c, logic ls);
    cmd_chars.push_back(cll_pkg::in_item_t'{ch: c, line_start: ls});
  endfunction

  function void push_line(string s);
    int k;
    for (k = 0; k < s.len(); k++) push_char(s[k], k == 0);
  endfunction

  function void send_line();
    int k;
    for (k = 0; k < line_buf.size(); k++) push_char(line_buf[k], k == 0);
    body_chars += line_buf.size();
    lines_sent++;
    line_buf.delete();
  endfunction

  function logic [7:0] name_char();
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function logic [7:0] param_char();
    logic [7:0] c;
    do c = 8'($urandom_range(cll_pkg::CH_PRINT_LO, cll_pkg::CH_PRINT_HI));
    while (c == cll_pkg::CH_COMMA || c == cll_pkg::CH_CLOSE);
    return c;
  endfunction

  // keywords, near misses of them, or plain names
  function void add_name();
    string kw;
    int unsigned n, k, first;
    first = line_buf.size();
    if ($urandom_range(0, 2) == 0) begin
      kw = kw_names[$urandom_range(0, cll_pkg::KW_COUNT - 1)];
      case ($urandom_range(0, 3))
        0: n = kw.len() - 1;
        1: n = kw.len() + 1;
        default: n = kw.len();
      endcase
      for (k = 0; k < n; k++) line_buf.push_back(k < kw.len() ? kw[k] : name_char());
      if ($urandom_range(0, 5) == 0) line_buf[first + $urandom_range(0, n - 1)] = name_char();
    end else begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) line_buf.push_back(name_char());
    end
  endfunction

  function void add_token(int unsigned max_len);
    int unsigned n, k;
    if ($urandom_range(0, 19) == 0) return;
    n = $urandom_range(1, max_len);
    for (k = 0; k < n; k++) line_buf.push_back(param_char());
    if ($urandom_range(0, 3) == 0) begin
      line_buf[line_buf.size() - 1] = cll_pkg::CH_QUOTE;
      if (n > 1 && $urandom_range(0, 1) == 0) begin
        line_buf[line_buf.size() - n] = cll_pkg::CH_QUOTE;
      end
    end
  endfunction

  function void add_params(int unsigned n);
    int unsigned j;
    line_buf.push_back(cll_pkg::CH_OPEN);
    for (j = 0; j < n; j++) begin
      if (j != 0) line_buf.push_back(cll_pkg::CH_COMMA);
      add_token(5);
    end
    line_buf.push_back(cll_pkg::CH_CLOSE);
  endfunction

  // long line: name of name_len chars, then tokens until the line reaches target
  function void send_long_line(int unsigned name_len, int unsigned target);
    int unsigned k, first;
    for (k = 0; k < name_len; k++) line_buf.push_back(name_char());
    line_buf.push_back(cll_pkg::CH_OPEN);
    first = line_buf.size();
    while (line_buf.size() < target) begin
      if (line_buf.size() != first) line_buf.push_back(cll_pkg::CH_COMMA);
      for (k = $urandom_range(1, 8); k > 0; k--) line_buf.push_back(param_char());
    end
    line_buf.push_back(cll_pkg::CH_CLOSE);
    send_line();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_chan.valid <= 1'b0;
      in_chan.data <= '0;
      in_wait <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        lex_char(in_chan.data);
        chars_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (in_wait != 0) begin
          in_chan.valid <= 1'b0;
          in_wait <= in_wait - 1;
        end else if (cmd_chars.size() != 0) begin
          in_chan.valid <= 1'b1;
          in_chan.data <= cmd_chars.pop_front();
          in_wait <= idle_cycles(chars_accepted);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cll_pkg::res_t want;
    int unsigned w;
    if (rst) begin
      out_chan.ready <= 1'b0;
      out_wait <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (lexer_results.size() == 0) begin
          $error("result with nothing pending: kind %0d", out_chan.data.kind);
          failures++;
        end else begin
          want = lexer_results.pop_front();
          check_field("kind", want.kind, out_chan.data.kind);
          check_field("call_type", want.call_type, out_chan.data.call_type);
          check_field("error_code", want.error_code, out_chan.data.error_code);
          check_field("name_end", want.name_end, out_chan.data.name_end);
          check_field("param_count", want.param_count, out_chan.data.param_count);
          check_field("param_index", want.param_index, out_chan.data.param_index);
          check_field("param_start", want.param_start, out_chan.data.param_start);
          check_field("param_end", want.param_end, out_chan.data.param_end);
          check_field("param_is_string", want.param_is_string,
                      out_chan.data.param_is_string);
          check_field("last", want.last, out_chan.data.last);
          case (want.kind)
            cll_pkg::KIND_TOKEN: tokens_seen++;
            cll_pkg::KIND_DONE: done_seen++;
            default: errors_seen++;
          endcase
        end
        results_seen++;
        w = idle_cycles(results_seen + 75);
        out_wait <= w;
        out_chan.ready <= (w == 0);
      end else if (out_wait != 0) begin
        out_wait <= out_wait - 1;
        out_chan.ready <= (out_wait == 1);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $error("no item moved for %0d cycles, %0d results pending", STALL_LIMIT,
             lexer_results.size());
      $display("[command_line_call_lexer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned sel, k;

    // characters before any line start are dropped
    push_char("q", 1'b0);
    push_line("lf()");
    push_char("z", 1'b0);
    // lone quote token, then a quoted token
    push_line("f(\",\"ab\")");
    push_line("(");
    push_line("w");
    push_char(8'hFF, 1'b0);
    push_line("s(");
    push_char(8'h00, 1'b0);
    // restart in the middle of a line, then an empty last token
    push_line("x(a");
    push_line("set(1,)");

    // lines that run into the length limit, and one of random length close to it
    send_long_line(255, 256);
    send_long_line(20, 254);
    for (k = 0; k < 260; k++) line_buf.push_back(name_char());
    send_line();

    body_chars = 0;
    while (body_chars < RANDOM_CHARS) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        for (k = $urandom_range(1, 6); k > 0; k--) begin
          push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end else begin
        if ($urandom_range(0, 19) != 0) add_name();
        add_params($urandom_range(0, 4));
        if (sel < 18) begin
          line_buf = line_buf[0:$urandom_range(0, line_buf.size() - 1)];
        end else if (sel < 28) begin
          line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        send_line();
        if ($urandom_range(0, 3) == 0) begin
          for (k = $urandom_range(1, 3); k > 0; k--) push_char(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
    chars_total = cmd_chars.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (chars_accepted != chars_total || lexer_results.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);

    if (lexer_results.size() != 0) begin
      $error("%0d results never arrived", lexer_results.size());
      failures++;
    end
    $display("sent %0d characters in %0d command lines plus noise and restarts",
             chars_total, lines_sent);
    $display("checked %0d tokens, %0d done and %0d error results", tokens_seen, done_seen,
             errors_seen);
    if (failures == 0) begin
      $display("[command_line_call_lexer] OK");
    end else begin
      $display("[command_line_call_lexer] ERROR");
    end
    $finish;
  end

endmodule
